/* sv/assert_macros.svh */
// assertion macros shared by the checker files
// clocked on clk, disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge
`define BDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define BDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/bds_pkg.sv */
// shared constants, command and status structs for the statistics block
// no dependencies
`default_nettype none

package bds_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int FRAC_BITS   = 16;
  localparam int PQ_BITS     = 16;
  localparam int D_W         = SAMPLE_BITS + FRAC_BITS;
  localparam int OUT_W       = 48;
  localparam int CV_W        = 32;
  localparam int MUL_CHUNK   = 16;
  localparam int MUL_STEPS   = D_W / MUL_CHUNK;
  localparam int MUL_CW      = 2;
  localparam int SQ_CW       = $clog2(D_W);
  localparam int PCT_NUM     = 6;
  localparam int PCT_KW      = 3;
  localparam int DEFAULT_MAX_SAMPLES = 1024;

  // 100 percent in Q.16
  localparam logic [D_W-1:0] CV_SCALE = D_W'(6553600);

  // percentile points in Q0.16, median first
  function automatic logic [PQ_BITS-1:0] pct_point(input logic [PCT_KW-1:0] k);
    logic [PQ_BITS-1:0] p;
    unique case (k)
      3'd0:    p = 16'd32768;
      3'd1:    p = 16'd3277;
      3'd2:    p = 16'd16384;
      3'd3:    p = 16'd49152;
      3'd4:    p = 16'd62259;
      3'd5:    p = 16'd64881;
      default: p = '0;
    endcase
    return p;
  endfunction

  typedef struct packed {
    logic accept;
    logic ins_read;
    logic ins_cmp;
    logic mean_start;
    logic mean_take;
    logic v_read;
    logic v_mul;
    logic v_take;
    logic var_start;
    logic var_take;
    logic sq_start;
    logic sq_take;
    logic cvm_start;
    logic cvd_start;
    logic cv_take;
    logic p_lo;
    logic p_hi;
    logic p_mul;
    logic p_take;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic j_zero;
    logic ins_gt;
    logic div_done;
    logic mul_done;
    logic sq_done;
    logic v_last;
    logic mean_zero;
    logic p_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* sv/batch_descriptive_statistics.sv */
// top level of the batch statistics block: sequencer plus datapath
// depends on bds_pkg, bds_ctrl, bds_dp (and through it bds_ram, bds_div)
//
//  channel | handshake                   | payload
//  --------+-----------------------------+------------------------------------------
//  sample  | sample_valid / sample_ready | sample_value, last_sample
//  result  | result_valid / result_ready | status, min/max, mean, median, std,
//          |                             | pct_05..pct_99, variation_pct
//
// each sample item is kept sorted by an insertion walk through the sample ram, which
//   moves every stored sample larger than it up one place; the next sample is taken
//   only once the walk is done
// an item marked last then runs the batch end (serial divisions for mean, variance
//   and, unless the mean is zero, cv; the root, a variance step per sample, six percentiles)
// rst is synchronous; the sample ram needs no clearing pass, only written entries
//   are read; a finished result waits in the output register while new samples load
`default_nettype none

module batch_descriptive_statistics #(
  parameter int MAX_SAMPLES = bds_pkg::DEFAULT_MAX_SAMPLES
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            sample_valid,
  output logic                                 sample_ready,
  input  wire logic [bds_pkg::SAMPLE_BITS-1:0] sample_value,
  input  wire logic                            last_sample,
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output logic                                 status,
  output logic      [bds_pkg::SAMPLE_BITS-1:0] min_value,
  output logic      [bds_pkg::SAMPLE_BITS-1:0] max_value,
  output logic      [bds_pkg::OUT_W-1:0]       mean_value,
  output logic      [bds_pkg::OUT_W-1:0]       median_value,
  output logic      [bds_pkg::OUT_W-1:0]       std_deviation,
  output logic      [bds_pkg::OUT_W-1:0]       pct_05,
  output logic      [bds_pkg::OUT_W-1:0]       pct_25,
  output logic      [bds_pkg::OUT_W-1:0]       pct_75,
  output logic      [bds_pkg::OUT_W-1:0]       pct_95,
  output logic      [bds_pkg::OUT_W-1:0]       pct_99,
  output logic      [bds_pkg::CV_W-1:0]        variation_pct
);

  import bds_pkg::*;

  // commands from the sequencer, status back from the datapath
  cmd_t  cmd;
  stat_t st;

  // sequencer: accepts items in idle, walks insertion and batch-end steps
  bds_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .last_sample  (last_sample),
    .sample_ready (sample_ready),
    .cmd          (cmd),
    .st           (st)
  );

  // datapath: sorted store, sum, arithmetic units, output register
  bds_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .sample_value  (sample_value),
    .result_ready  (result_ready),
    .result_valid  (result_valid),
    .status        (status),
    .min_value     (min_value),
    .max_value     (max_value),
    .mean_value    (mean_value),
    .median_value  (median_value),
    .std_deviation (std_deviation),
    .pct_05        (pct_05),
    .pct_25        (pct_25),
    .pct_75        (pct_75),
    .pct_95        (pct_95),
    .pct_99        (pct_99),
    .variation_pct (variation_pct)
  );

endmodule

`default_nettype wire

/* sv/bds_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module bds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/bds_div.sv */
// restoring divider, one quotient bit per cycle
// no dependencies
`default_nettype none

module bds_div #(
  parameter int NUM_W = 107,
  parameter int DEN_W = 48
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quo,
  output logic                  done
);

  localparam int CW = $clog2(NUM_W);

  logic [NUM_W-1:0] sh;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem, sh[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign quo    = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh    <= num;
      rem   <= '0;
      den_r <= den;
      cnt   <= CW'(NUM_W - 1);
    end else if (busy) begin
      rem <= ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      sh  <= {sh[NUM_W-2:0], ge};
      cnt <= cnt - CW'(1);
    end
  end

endmodule

`default_nettype wire

/* sv/bds_ctrl.sv */
// sequencer for load, insertion, mean, variance, root, cv and percentile steps
// depends on bds_pkg
`default_nettype none

module bds_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          sample_valid,
  input  wire logic          last_sample,
  output logic               sample_ready,
  output bds_pkg::cmd_t      cmd,
  input  wire bds_pkg::stat_t st
);

  import bds_pkg::*;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_INS_RD  = 5'd1;
  localparam logic [4:0] ST_INS_CMP = 5'd2;
  localparam logic [4:0] ST_MEAN    = 5'd3;
  localparam logic [4:0] ST_MEAN_W  = 5'd4;
  localparam logic [4:0] ST_V_RD    = 5'd5;
  localparam logic [4:0] ST_V_MUL   = 5'd6;
  localparam logic [4:0] ST_V_W     = 5'd7;
  localparam logic [4:0] ST_VAR     = 5'd8;
  localparam logic [4:0] ST_VAR_W   = 5'd9;
  localparam logic [4:0] ST_SQ      = 5'd10;
  localparam logic [4:0] ST_SQ_W    = 5'd11;
  localparam logic [4:0] ST_CV_M    = 5'd12;
  localparam logic [4:0] ST_CV_MW   = 5'd13;
  localparam logic [4:0] ST_CV_D    = 5'd14;
  localparam logic [4:0] ST_CV_DW   = 5'd15;
  localparam logic [4:0] ST_P_A     = 5'd16;
  localparam logic [4:0] ST_P_B     = 5'd17;
  localparam logic [4:0] ST_P_C     = 5'd18;
  localparam logic [4:0] ST_P_W     = 5'd19;
  localparam logic [4:0] ST_DONE    = 5'd20;

  logic [4:0] state, state_next;
  logic       last_r, last_r_next;

  assign sample_ready = (state == ST_IDLE);

  always_comb begin
    cmd         = '0;
    state_next  = state;
    last_r_next = last_r;
    unique case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          cmd.accept  = 1'b1;
          last_r_next = last_sample;
          if (st.full) begin
            state_next = last_sample ? ST_MEAN : ST_IDLE;
          end else begin
            state_next = ST_INS_RD;
          end
        end
      end
      ST_INS_RD: begin
        cmd.ins_read = 1'b1;
        if (st.j_zero) begin
          state_next = last_r ? ST_MEAN : ST_IDLE;
        end else begin
          state_next = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        cmd.ins_cmp = 1'b1;
        if (st.ins_gt) begin
          state_next = ST_INS_RD;
        end else begin
          state_next = last_r ? ST_MEAN : ST_IDLE;
        end
      end
      ST_MEAN: begin
        cmd.mean_start = 1'b1;
        state_next     = ST_MEAN_W;
      end
      ST_MEAN_W: begin
        if (st.div_done) begin
          cmd.mean_take = 1'b1;
          state_next    = ST_V_RD;
        end
      end
      ST_V_RD: begin
        cmd.v_read = 1'b1;
        state_next = ST_V_MUL;
      end
      ST_V_MUL: begin
        cmd.v_mul  = 1'b1;
        state_next = ST_V_W;
      end
      ST_V_W: begin
        if (st.mul_done) begin
          cmd.v_take = 1'b1;
          state_next = st.v_last ? ST_VAR : ST_V_RD;
        end
      end
      ST_VAR: begin
        cmd.var_start = 1'b1;
        state_next    = ST_VAR_W;
      end
      ST_VAR_W: begin
        if (st.div_done) begin
          cmd.var_take = 1'b1;
          state_next   = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.sq_start = 1'b1;
        state_next   = ST_SQ_W;
      end
      ST_SQ_W: begin
        if (st.sq_done) begin
          cmd.sq_take = 1'b1;
          state_next  = st.mean_zero ? ST_P_A : ST_CV_M;
        end
      end
      ST_CV_M: begin
        cmd.cvm_start = 1'b1;
        state_next    = ST_CV_MW;
      end
      ST_CV_MW: begin
        if (st.mul_done) begin
          state_next = ST_CV_D;
        end
      end
      ST_CV_D: begin
        cmd.cvd_start = 1'b1;
        state_next    = ST_CV_DW;
      end
      ST_CV_DW: begin
        if (st.div_done) begin
          cmd.cv_take = 1'b1;
          state_next  = ST_P_A;
        end
      end
      ST_P_A: begin
        cmd.p_lo   = 1'b1;
        state_next = ST_P_B;
      end
      ST_P_B: begin
        cmd.p_hi   = 1'b1;
        state_next = ST_P_C;
      end
      ST_P_C: begin
        cmd.p_mul  = 1'b1;
        state_next = ST_P_W;
      end
      ST_P_W: begin
        if (st.mul_done) begin
          cmd.p_take = 1'b1;
          state_next = st.p_last ? ST_DONE : ST_P_A;
        end
      end
      ST_DONE: begin
        if (st.out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      last_r <= 1'b0;
    end else begin
      state  <= state_next;
      last_r <= last_r_next;
    end
  end

endmodule

`default_nettype wire

/* sv/bds_dp.sv */
// datapath: sample store, running sum, multiplier, divider, root and result registers
// depends on bds_pkg, bds_ram, bds_div
`default_nettype none

module bds_dp #(
  parameter int MAX_SAMPLES = bds_pkg::DEFAULT_MAX_SAMPLES
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire bds_pkg::cmd_t                      cmd,
  output bds_pkg::stat_t                          st,
  input  wire logic [bds_pkg::SAMPLE_BITS-1:0]    sample_value,
  input  wire logic                               result_ready,
  output logic                                    result_valid,
  output logic                                    status,
  output logic      [bds_pkg::SAMPLE_BITS-1:0]    min_value,
  output logic      [bds_pkg::SAMPLE_BITS-1:0]    max_value,
  output logic      [bds_pkg::OUT_W-1:0]          mean_value,
  output logic      [bds_pkg::OUT_W-1:0]          median_value,
  output logic      [bds_pkg::OUT_W-1:0]          std_deviation,
  output logic      [bds_pkg::OUT_W-1:0]          pct_05,
  output logic      [bds_pkg::OUT_W-1:0]          pct_25,
  output logic      [bds_pkg::OUT_W-1:0]          pct_75,
  output logic      [bds_pkg::OUT_W-1:0]          pct_95,
  output logic      [bds_pkg::OUT_W-1:0]          pct_99,
  output logic      [bds_pkg::CV_W-1:0]           variation_pct
);

  import bds_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int SQ_W   = 2 * D_W;
  localparam int ACC_W  = SQ_W + CNT_W;

  // batch state
  logic [CNT_W-1:0]       count;
  logic [SUM_W-1:0]       sum;
  logic                   ovf;
  logic [SAMPLE_BITS-1:0] x_r;
  logic [ADDR_W-1:0]      j;
  logic [ADDR_W-1:0]      i;
  logic [PCT_KW-1:0]      k;

  // intermediate results
  logic [D_W-1:0]         mean;
  logic [ACC_W-1:0]       acc;
  logic [SQ_W-1:0]        var_r;
  logic [D_W-1:0]         sd;
  logic [CV_W-1:0]        cv;
  logic [SAMPLE_BITS-1:0] minv, maxv, slo;
  logic [OUT_W-1:0]       pct [PCT_NUM];

  // sample store
  logic                   we;
  logic [ADDR_W-1:0]      waddr, raddr;
  logic [SAMPLE_BITS-1:0] wdata, rdata;

  bds_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // divider
  logic             div_start;
  logic [ACC_W-1:0] div_num, div_quo;
  logic [D_W-1:0]   div_den;
  logic             div_done;

  bds_div #(.NUM_W(ACC_W), .DEN_W(D_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  // percentile index
  logic [ADDR_W-1:0]         p_nm1, p_lo, p_hi;
  logic [PQ_BITS+ADDR_W-1:0] p_idx;
  logic [PQ_BITS-1:0]        p_f;

  assign p_nm1 = ADDR_W'(count - CNT_W'(1));
  assign p_idx = pct_point(k) * p_nm1;
  assign p_lo  = p_idx[PQ_BITS+ADDR_W-1:PQ_BITS];
  assign p_f   = p_idx[PQ_BITS-1:0];
  assign p_hi  = ((CNT_W'(p_lo) + CNT_W'(1)) < count) ? p_lo + ADDR_W'(1) : p_lo;

  // distance of a sample from the mean
  logic [D_W-1:0] xq, delta;
  assign xq    = {rdata, {FRAC_BITS{1'b0}}};
  assign delta = (xq >= mean) ? xq - mean : mean - xq;

  // store port
  always_comb begin
    we    = (cmd.ins_read && j == '0) || cmd.ins_cmp;
    waddr = j;
    wdata = (cmd.ins_cmp && rdata > x_r) ? rdata : x_r;
    priority if (cmd.ins_read) begin
      raddr = j - ADDR_W'(1);
    end else if (cmd.v_read) begin
      raddr = i;
    end else if (cmd.p_lo) begin
      raddr = p_lo;
    end else if (cmd.p_hi) begin
      raddr = p_hi;
    end else begin
      raddr = '0;
    end
  end

  // chunked multiplier signals
  logic                     mul_start, mul_busy, mul_done;
  logic [D_W-1:0]           mul_a_in, mul_b_in, mul_a, mul_b;
  logic [SQ_W-1:0]          mul_p;
  logic [MUL_CW-1:0]        mul_cnt;
  logic [D_W+MUL_CHUNK-1:0] mul_pp;

  // divider operands
  always_comb begin
    div_start = cmd.mean_start || cmd.var_start || cmd.cvd_start;
    priority if (cmd.mean_start) begin
      div_num = ACC_W'({sum, {FRAC_BITS{1'b0}}});
      div_den = D_W'(count);
    end else if (cmd.var_start) begin
      div_num = acc;
      div_den = D_W'(count);
    end else begin
      div_num = ACC_W'(mul_p);
      div_den = mean;
    end
  end

  // chunked multiplier, most significant chunk of b first
  assign mul_pp = mul_a * mul_b[D_W-1 -: MUL_CHUNK];

  always_comb begin
    mul_start = cmd.v_mul || cmd.cvm_start || cmd.p_mul;
    priority if (cmd.v_mul) begin
      mul_a_in = delta;
      mul_b_in = delta;
    end else if (cmd.cvm_start) begin
      mul_a_in = sd;
      mul_b_in = CV_SCALE;
    end else begin
      mul_a_in = D_W'(rdata - slo);
      mul_b_in = D_W'(p_f);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mul_done <= 1'b0;
    end else begin
      mul_done <= 1'b0;
      if (mul_start) begin
        mul_busy <= 1'b1;
      end else if (mul_busy && mul_cnt == '0) begin
        mul_busy <= 1'b0;
        mul_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start) begin
      mul_a   <= mul_a_in;
      mul_b   <= mul_b_in;
      mul_p   <= '0;
      mul_cnt <= MUL_CW'(MUL_STEPS - 1);
    end else if (mul_busy) begin
      mul_p   <= (mul_p << MUL_CHUNK) + SQ_W'(mul_pp);
      mul_b   <= mul_b << MUL_CHUNK;
      mul_cnt <= mul_cnt - MUL_CW'(1);
    end
  end

  // digit by digit square root, two radicand bits per cycle
  logic             sq_busy, sq_done;
  logic [SQ_W-1:0]  sq_v;
  logic [D_W:0]     sq_rem;
  logic [D_W-1:0]   sq_root;
  logic [SQ_CW-1:0] sq_cnt;
  logic [D_W+2:0]   sq_rem_sh, sq_trial;
  logic             sq_ge;

  assign sq_rem_sh = {sq_rem, sq_v[SQ_W-1 -: 2]};
  assign sq_trial  = {1'b0, sq_root, 2'b01};
  assign sq_ge     = sq_rem_sh >= sq_trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_done <= 1'b0;
    end else begin
      sq_done <= 1'b0;
      if (cmd.sq_start) begin
        sq_busy <= 1'b1;
      end else if (sq_busy && sq_cnt == '0) begin
        sq_busy <= 1'b0;
        sq_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_start) begin
      sq_v    <= var_r;
      sq_rem  <= '0;
      sq_root <= '0;
      sq_cnt  <= SQ_CW'(D_W - 1);
    end else if (sq_busy) begin
      sq_v    <= sq_v << 2;
      sq_rem  <= sq_ge ? (D_W+1)'(sq_rem_sh - sq_trial) : sq_rem_sh[D_W:0];
      sq_root <= {sq_root[D_W-2:0], sq_ge};
      sq_cnt  <= sq_cnt - SQ_CW'(1);
    end
  end

  // batch control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      sum          <= '0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (st.full) begin
          ovf <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
          sum   <= sum + SUM_W'(sample_value);
        end
      end
      if (cmd.publish) begin
        count        <= '0;
        sum          <= '0;
        ovf          <= 1'b0;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    if (cmd.accept && !st.full) begin
      x_r <= sample_value;
      j   <= ADDR_W'(count);
    end
    if (cmd.ins_cmp && rdata > x_r) begin
      j <= j - ADDR_W'(1);
    end
    if (cmd.mean_take) begin
      mean <= div_quo[D_W-1:0];
      i    <= '0;
      acc  <= '0;
    end
    if (cmd.v_mul) begin
      if (i == '0) begin
        minv <= rdata;
      end
      if (st.v_last) begin
        maxv <= rdata;
      end
    end
    if (cmd.v_take) begin
      acc <= acc + ACC_W'(mul_p);
      i   <= i + ADDR_W'(1);
    end
    if (cmd.var_take) begin
      var_r <= div_quo[SQ_W-1:0];
    end
    if (cmd.sq_take) begin
      sd <= sq_root;
      k  <= '0;
      cv <= '0;
    end
    if (cmd.cv_take) begin
      cv <= (|div_quo[ACC_W-1:CV_W]) ? '1 : div_quo[CV_W-1:0];
    end
    if (cmd.p_hi) begin
      slo <= rdata;
    end
    if (cmd.p_take) begin
      pct[k] <= OUT_W'({slo, {FRAC_BITS{1'b0}}}) + OUT_W'(mul_p);
      k      <= k + PCT_KW'(1);
    end
    if (cmd.publish) begin
      status        <= ovf;
      min_value     <= minv;
      max_value     <= maxv;
      mean_value    <= OUT_W'(mean);
      median_value  <= pct[0];
      std_deviation <= OUT_W'(sd);
      pct_05        <= pct[1];
      pct_25        <= pct[2];
      pct_75        <= pct[3];
      pct_95        <= pct[4];
      pct_99        <= pct[5];
      variation_pct <= cv;
    end
  end

  always_comb begin
    st.full      = (count == CNT_W'(MAX_SAMPLES));
    st.j_zero    = (j == '0);
    st.ins_gt    = (rdata > x_r);
    st.div_done  = div_done;
    st.mul_done  = mul_done;
    st.sq_done   = sq_done;
    st.v_last    = ((CNT_W'(i) + CNT_W'(1)) == count);
    st.mean_zero = (mean == '0);
    st.p_last    = (k == PCT_KW'(PCT_NUM - 1));
    st.out_free  = !result_valid || result_ready;
  end

endmodule

`default_nettype wire

/* sv/bds_check.sv */
// port-level checks on the result channel of the statistics block, bound to the top
// depends on assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module bds_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [31:0] min_value,
  input wire logic [31:0] max_value,
  input wire logic [47:0] median_value,
  input wire logic [47:0] pct_05,
  input wire logic [47:0] pct_25,
  input wire logic [47:0] pct_75,
  input wire logic [47:0] pct_95,
  input wire logic [47:0] pct_99
);

  `BDS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid, "result dropped while stalled")
  `BDS_ASSERT(a_min_max, !result_valid || min_value <= max_value, "min above max")
  `BDS_ASSERT(a_median_range, !result_valid || (median_value >= {min_value, 16'h0} && median_value <= {max_value, 16'h0}), "median outside min and max")
  `BDS_ASSERT(a_pct_order, !result_valid || (pct_05 <= pct_25 && pct_25 <= median_value && median_value <= pct_75 && pct_75 <= pct_95 && pct_95 <= pct_99), "percentiles out of order")

endmodule

bind batch_descriptive_statistics bds_check u_check (.*);

`default_nettype wire

/* tb/sv/batch_descriptive_statistics_tb.sv */
// self-checking testbench for batch_descriptive_statistics
// depends on bds_pkg and the block's rtl; sends batches of samples and checks each result
`timescale 1ns / 100ps
`default_nettype none

module batch_descriptive_statistics_tb;
  import bds_pkg::*;

  localparam int STORE_DEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int CALM_TAIL = 150;
  localparam int RANDOM_ITEMS = 250;

  typedef struct {
    bit [31:0] value;
    bit        last;
  } sample_item_t;

  typedef struct {
    bit              status;
    bit [31:0]       min_v;
    bit [31:0]       max_v;
    bit [OUT_W-1:0]  mean_v;
    bit [OUT_W-1:0]  median_v;
    bit [OUT_W-1:0]  std_v;
    bit [OUT_W-1:0]  p05;
    bit [OUT_W-1:0]  p25;
    bit [OUT_W-1:0]  p75;
    bit [OUT_W-1:0]  p95;
    bit [OUT_W-1:0]  p99;
    bit [CV_W-1:0]   cv;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic [SAMPLE_BITS-1:0] sample_value = '0;
  logic last_sample = 1'b0;
  logic result_ready = 1'b0;
  logic sample_ready, result_valid, status;
  logic [SAMPLE_BITS-1:0] min_value, max_value;
  logic [OUT_W-1:0] mean_value, median_value, std_deviation;
  logic [OUT_W-1:0] pct_05, pct_25, pct_75, pct_95, pct_99;
  logic [CV_W-1:0] variation_pct;

  sample_item_t pending_samples[$];
  stats_t       expected_stats[$];
  bit [31:0]    batch_samples[$];
  bit [41:0]    batch_sum;
  bit           batch_dropped;
  int           mismatches;
  bit           calm;
  int           send_gap, recv_gap, idle_cycles;

  batch_descriptive_statistics u_dut (
    .clk, .rst, .sample_valid, .sample_ready, .sample_value, .last_sample,
    .result_valid, .result_ready, .status, .min_value, .max_value, .mean_value,
    .median_value, .std_deviation, .pct_05, .pct_25, .pct_75, .pct_95, .pct_99,
    .variation_pct
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // interpolated percentile at q0.16 point over the sorted batch
  function automatic bit [OUT_W-1:0] percentile(bit [31:0] s[$], bit [15:0] pq);
    bit [63:0] idx, lo, hi, frac, part;
    int n;
    n = s.size();
    idx = 64'(pq) * 64'(n - 1);
    lo = idx >> 16;
    frac = idx & 64'hFFFF;
    hi = (lo + 1 < n) ? lo + 1 : lo;
    part = 64'(s[hi] - s[lo]) * frac;
    return OUT_W'((64'(s[lo]) << FRAC_BITS) + part);
  endfunction

  // closes the current batch and queues the statistics it should produce
  task automatic close_batch();
    bit [31:0]  sorted[$];
    bit [127:0] sq_sum, var_q, trial, ratio;
    bit [63:0]  mean_q, dev, root;
    stats_t     st;
    int         n;
    sorted = batch_samples;
    sorted.sort();
    n = sorted.size();
    mean_q = (64'(batch_sum) << FRAC_BITS) / n;
    sq_sum = '0;
    foreach (batch_samples[i]) begin
      dev = (64'(batch_samples[i]) << FRAC_BITS);
      dev = dev >= mean_q ? dev - mean_q : mean_q - dev;
      sq_sum += 128'(dev) * 128'(dev);
    end
    var_q = sq_sum / n;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      trial = 128'(root | (64'd1 << b));
      if (trial * trial <= var_q) root = trial[63:0];
    end
    st.status = batch_dropped;
    st.min_v = sorted[0];
    st.max_v = sorted[n-1];
    st.mean_v = OUT_W'(mean_q);
    st.std_v = OUT_W'(root);
    st.median_v = percentile(sorted, 16'd32768);
    st.p05 = percentile(sorted, 16'd3277);
    st.p25 = percentile(sorted, 16'd16384);
    st.p75 = percentile(sorted, 16'd49152);
    st.p95 = percentile(sorted, 16'd62259);
    st.p99 = percentile(sorted, 16'd64881);
    if (mean_q == 0) st.cv = '0;
    else begin
      // std times 100 percent in q.16, over the mean
      ratio = (128'(root) * 128'(6553600)) / 128'(mean_q);
      st.cv = (ratio > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : ratio[31:0];
    end
    expected_stats.push_back(st);
    batch_samples.delete();
    batch_sum = '0;
    batch_dropped = 1'b0;
  endtask

  task automatic take_sample(bit [31:0] v, bit lst);
    if (batch_samples.size() < STORE_DEPTH) begin
      batch_samples.push_back(v);
      batch_sum += 42'(v);
    end else begin
      batch_dropped = 1'b1;
    end
    if (lst) close_batch();
  endtask

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %h, want %h", field, got, want);
    mismatches++;
  endtask

  task automatic add_batch(int len, int mode);
    bit [31:0] base;
    sample_item_t it;
    base = $urandom;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: it.value = $urandom;
        1: it.value = $urandom_range(0, 15);
        2: it.value = base;
        3: it.value = base + $urandom_range(0, 255);
        default: it.value = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 9)
                                                 : $urandom_range(0, 9);
      endcase
      it.last = (i == len - 1);
      pending_samples.push_back(it);
    end
  endtask

  // sender: items come from the pending queue, with random bursts of idle cycles
  always @(posedge clk) begin
    sample_item_t it;
    if (rst) begin
      sample_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (sample_valid && sample_ready) take_sample(sample_value, last_sample);
      if (!(sample_valid && !sample_ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          sample_valid <= 1'b0;
        end else if (pending_samples.size() == 0) begin
          sample_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 2);
          sample_valid <= 1'b0;
        end else begin
          it = pending_samples.pop_front();
          sample_valid <= 1'b1;
          sample_value <= it.value;
          last_sample <= it.last;
        end
      end
    end
  end

  // receiver: random stall bursts, every accepted result checked field by field
  always @(posedge clk) begin
    stats_t st;
    if (rst) begin
      result_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_stats.size() == 0) begin
          $display("result arrived with nothing expected");
          mismatches++;
        end else begin
          st = expected_stats.pop_front();
          if (status !== st.status) report("status", status, st.status);
          if (min_value !== st.min_v) report("min_value", min_value, st.min_v);
          if (max_value !== st.max_v) report("max_value", max_value, st.max_v);
          if (mean_value !== st.mean_v) report("mean_value", mean_value, st.mean_v);
          if (median_value !== st.median_v)
            report("median_value", median_value, st.median_v);
          if (std_deviation !== st.std_v) report("std_deviation", std_deviation, st.std_v);
          if (pct_05 !== st.p05) report("pct_05", pct_05, st.p05);
          if (pct_25 !== st.p25) report("pct_25", pct_25, st.p25);
          if (pct_75 !== st.p75) report("pct_75", pct_75, st.p75);
          if (pct_95 !== st.p95) report("pct_95", pct_95, st.p95);
          if (pct_99 !== st.p99) report("pct_99", pct_99, st.p99);
          if (variation_pct !== st.cv) report("variation_pct", variation_pct, st.cv);
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        result_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        recv_gap = $urandom_range(0, 2);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready))
      idle_cycles = 0;
    else if (++idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int sent;
    mismatches = 0;
    calm = 1'b0;
    batch_sum = '0;
    batch_dropped = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: single samples at the extremes, all-zero batch, two-point spread
    pending_samples.push_back('{32'd0, 1'b1});
    pending_samples.push_back('{32'hFFFF_FFFF, 1'b1});
    pending_samples.push_back('{32'd0, 1'b0});
    pending_samples.push_back('{32'hFFFF_FFFF, 1'b1});
    for (int i = 0; i < 4; i++) pending_samples.push_back('{32'd0, i == 3});
    for (int i = 0; i < 6; i++) pending_samples.push_back('{32'(i == 5), i == 5});
    for (int i = 0; i < 5; i++) pending_samples.push_back('{32'(5 - i), i == 4});

    // hold off until everything so far has come back
    wait (pending_samples.size() == 0 && !sample_valid && expected_stats.size() == 0);
    @(posedge clk);

    // overfull batch, ascending so inserts stay short; the last mark falls on a dropped one
    for (int i = 0; i < STORE_DEPTH + 6; i++)
      pending_samples.push_back('{32'(i * 4000037), i == STORE_DEPTH + 5});

    // random batches, mostly short
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      add_batch(len, $urandom_range(0, 4));
      sent += len;
    end

    wait (pending_samples.size() < CALM_TAIL);
    calm = 1'b1;
    wait (pending_samples.size() == 0 && !sample_valid && expected_stats.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_stats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
